>>> rtl/core/periodic_timer_bank_defines.svh
// Assertion macros for the periodic timer bank.
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define PTB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("periodic_timer_bank: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PTB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("periodic_timer_bank: next-cycle check failed");

`else

`define PTB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PTB_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/core/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

    // Bank geometry and field widths
    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = 4;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 2;

    localparam logic [DATA_W-1:0] ALL_ONES   = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] PERIOD_MIN = DATA_W'(1);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_TIMERS - 1);

    // Item kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM
    } ptb_state_t;

    // Commands from the sequencer to the timer store
    typedef struct packed {
        logic              start;
        logic              stop;
        logic              upd;
        logic [IDX_W-1:0]  wr_idx;
        logic [IDX_W-1:0]  rd_idx;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] rem;
    } ptb_store_cmd_t;

endpackage

>>> rtl/core/ptb_store.sv
// Timer store: period and remaining-count memories plus running flags.
module ptb_store import ptb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ptb_store_cmd_t        cmd,
    output logic [NUM_TIMERS-1:0] run,
    output logic [DATA_W-1:0]     rd_rem,
    output logic [DATA_W-1:0]     rd_period
);

    logic [DATA_W-1:0]     period_mem [NUM_TIMERS];
    logic [DATA_W-1:0]     rem_mem    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg;
    logic [DATA_W-1:0]     rd_rem_reg;
    logic [DATA_W-1:0]     rd_period_reg;

    // Running flags: set by start, cleared by stop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (cmd.start) begin
            run_reg[cmd.wr_idx] <= 1'b1;
        end else if (cmd.stop) begin
            run_reg[cmd.wr_idx] <= 1'b0;
        end
    end

    // Write the memories; a timer's entries are only used while it runs
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            period_mem[cmd.wr_idx] <= cmd.period;
        end
        if (cmd.start || cmd.upd) begin
            rem_mem[cmd.wr_idx] <= cmd.rem;
        end
    end

    // Registered read at the scan address
    always_ff @(posedge aclk) begin
        rd_rem_reg    <= rem_mem[cmd.rd_idx];
        rd_period_reg <= period_mem[cmd.rd_idx];
    end

    assign run       = run_reg;
    assign rd_rem    = rd_rem_reg;
    assign rd_period = rd_period_reg;

endmodule

>>> rtl/core/ptb_unit.sv
// Shared update unit: compare and subtract one timer, fold into the running minimum.
module ptb_unit import ptb_pkg::*; (
    input  logic              running,
    input  logic [DATA_W-1:0] rem,
    input  logic [DATA_W-1:0] period,
    input  logic [DATA_W-1:0] elapsed,
    input  logic [DATA_W-1:0] best,
    output logic              fire,
    output logic [DATA_W-1:0] new_rem,
    output logic [DATA_W-1:0] new_best
);

    logic still_counting;

    // Decrement or expire and reload
    always_comb begin
        still_counting = rem > elapsed;
        fire           = running && !still_counting;
        new_rem        = still_counting ? (rem - elapsed) : period;
    end

    // Track the smallest remaining count over running timers
    always_comb begin
        if (running && (new_rem < best)) begin
            new_best = new_rem;
        end else begin
            new_best = best;
        end
    end

endmodule

>>> rtl/core/periodic_timer_bank.sv
// Periodic timer bank: sequencer, output register and assertions.
//
// Input channel (s_*): one word per item. kind selects start, stop or
// advance; timer_index addresses start and stop, period is the reload value
// of a start (0 loads as 1), elapsed is the tick count of an advance.
// Start and stop take effect at acceptance, give no result, and the bank is
// ready again in the next cycle. An advance walks the timers one per cycle
// through a single compare/subtract unit: each expired timer produces a word
// with m_is_expiry set, in ascending index order, and a final summary word
// (m_last set) carries the smallest remaining count, or all ones if no timer
// runs. After acceptance an advance occupies the bank through the walk
// (ST_SCAN) and the summary (ST_SUM), and takes no new item until back in
// ST_IDLE; the walk goes through the store's single read port.
// Results pass through one output register: the bank takes the next item
// while the summary still waits there. If the receiver stalls while a timer
// fires, the walk holds on that timer until the register frees.
// Reset (synchronous, active low) stops all timers and empties the output.
`include "periodic_timer_bank_defines.svh"

module periodic_timer_bank import ptb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [IDX_W-1:0]  s_timer_index,
    input  logic [DATA_W-1:0] s_period,
    input  logic [DATA_W-1:0] s_elapsed,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_expiry,
    output logic [IDX_W-1:0]  m_fired_index,
    output logic [DATA_W-1:0] m_next_timeout,
    output logic              m_last
);

    ptb_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [DATA_W-1:0] elapsed_reg, elapsed_next;
    logic [DATA_W-1:0] best_reg, best_next;

    logic              m_valid_reg;
    logic              m_is_expiry_reg, m_is_expiry_next;
    logic [IDX_W-1:0]  m_fired_index_reg, m_fired_index_next;
    logic [DATA_W-1:0] m_next_timeout_reg, m_next_timeout_next;
    logic              m_last_reg, m_last_next;

    ptb_store_cmd_t        cmd;
    logic [NUM_TIMERS-1:0] run;
    logic [DATA_W-1:0]     rd_rem;
    logic [DATA_W-1:0]     rd_period;
    logic                  cur_run;
    logic                  fire;
    logic [DATA_W-1:0]     new_rem;
    logic [DATA_W-1:0]     new_best;

    logic s_accept;
    logic out_full;
    logic out_load;
    logic scan_stall;

    ptb_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .run       (run),
        .rd_rem    (rd_rem),
        .rd_period (rd_period)
    );

    assign cur_run = run[scan_idx_reg];

    ptb_unit u_unit (
        .running  (cur_run),
        .rem      (rd_rem),
        .period   (rd_period),
        .elapsed  (elapsed_reg),
        .best     (best_reg),
        .fire     (fire),
        .new_rem  (new_rem),
        .new_best (new_best)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_full = m_valid_reg && !m_ready;

    // Sequencer: next state, store commands and output word
    always_comb begin
        state_next          = state_reg;
        scan_idx_next       = scan_idx_reg;
        elapsed_next        = elapsed_reg;
        best_next           = best_reg;
        out_load            = 1'b0;
        scan_stall          = 1'b0;
        m_is_expiry_next    = 1'b0;
        m_fired_index_next  = '0;
        m_next_timeout_next = '0;
        m_last_next         = 1'b0;

        cmd.start  = 1'b0;
        cmd.stop   = 1'b0;
        cmd.upd    = 1'b0;
        cmd.wr_idx = s_timer_index;
        cmd.rd_idx = '0;
        cmd.period = (s_period != '0) ? s_period : PERIOD_MIN;
        cmd.rem    = (s_period != '0) ? s_period : PERIOD_MIN;

        unique case (state_reg)
            ST_IDLE: begin
                // Every 4-bit index lies inside the bank, so no range check
                if (s_accept) begin
                    priority if (s_kind == KIND_START) begin
                        cmd.start = !run[s_timer_index];
                    end else if (s_kind == KIND_STOP) begin
                        cmd.stop = 1'b1;
                    end else if (s_kind == KIND_ADVANCE) begin
                        elapsed_next  = s_elapsed;
                        best_next     = ALL_ONES;
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN: begin
                // Hold on a firing timer while the output word is still owned
                scan_stall = fire && out_full;
                cmd.wr_idx = scan_idx_reg;
                cmd.rem    = new_rem;
                if (scan_stall) begin
                    cmd.rd_idx = scan_idx_reg;
                end else begin
                    cmd.rd_idx = scan_idx_reg + IDX_W'(1);
                    cmd.upd    = cur_run;
                    best_next  = new_best;
                    if (fire) begin
                        out_load           = 1'b1;
                        m_is_expiry_next   = 1'b1;
                        m_fired_index_next = scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_IDX) begin
                        state_next = ST_SUM;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_SUM: begin
                // Emit the summary word once the output register frees
                if (!out_full) begin
                    out_load            = 1'b1;
                    m_next_timeout_next = best_reg;
                    m_last_next         = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        elapsed_reg  <= elapsed_next;
        best_reg     <= best_next;
        if (out_load) begin
            m_is_expiry_reg    <= m_is_expiry_next;
            m_fired_index_reg  <= m_fired_index_next;
            m_next_timeout_reg <= m_next_timeout_next;
            m_last_reg         <= m_last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_is_expiry    = m_is_expiry_reg;
    assign m_fired_index  = m_fired_index_reg;
    assign m_next_timeout = m_next_timeout_reg;
    assign m_last         = m_last_reg;

    // A stalled scan keeps its place
    `PTB_ASSERT_NXT(a_stall_holds, aclk, aresetn, scan_stall, (state_reg == ST_SCAN) && $stable(scan_idx_reg))
    // An accepted advance starts its walk at the first timer
    `PTB_ASSERT_NXT(a_advance_starts, aclk, aresetn, s_accept && (s_kind == KIND_ADVANCE), (state_reg == ST_SCAN) && (scan_idx_reg == '0))
    // The summary word never reports an expiry
    `PTB_ASSERT_IMP(a_summary_form, aclk, aresetn, m_valid_reg && m_last_reg, !m_is_expiry_reg && (m_fired_index_reg == '0))

endmodule

>>> tb/sv/periodic_timer_bank_tb.sv
// Self-checking testbench for the periodic timer bank: directed, stall and random tests.
module periodic_timer_bank_tb import ptb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Fourth kind code, which the bank ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // Cycles for the bank to settle after the last expected word
    localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;

    typedef struct packed {
        logic              is_expiry;
        logic [IDX_W-1:0]  fired_index;
        logic [DATA_W-1:0] next_timeout;
        logic              last;
    } timer_report_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [IDX_W-1:0]  s_timer_index;
    logic [DATA_W-1:0] s_period;
    logic [DATA_W-1:0] s_elapsed;
    logic              m_valid;
    logic              m_ready;
    logic              m_is_expiry;
    logic [IDX_W-1:0]  m_fired_index;
    logic [DATA_W-1:0] m_next_timeout;
    logic              m_last;

    // Predicted timer state
    logic [DATA_W-1:0] timer_period [NUM_TIMERS];
    logic [DATA_W-1:0] timer_remaining [NUM_TIMERS];
    timer_report_t     pending_reports [$];

    int words_sent      = 0;
    int advances_sent   = 0;
    int reports_checked = 0;
    int fires_seen      = 0;
    int mismatch_count  = 0;
    int send_gap_hi     = 0;
    int recv_gap_hi     = 0;
    int receiver_hold   = 0;
    int longest_hold    = 0;

    periodic_timer_bank dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_timer_index  (s_timer_index),
        .s_period       (s_period),
        .s_elapsed      (s_elapsed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_expiry    (m_is_expiry),
        .m_fired_index  (m_fired_index),
        .m_next_timeout (m_next_timeout),
        .m_last         (m_last)
    );

    always #2 aclk = ~aclk;

    // Smallest remaining count over running timers, all ones if none runs
    function automatic logic [DATA_W-1:0] soonest_remaining();
        logic [DATA_W-1:0] soon;
        soon = ALL_ONES;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (timer_period[i] != '0 && timer_remaining[i] < soon) begin
                soon = timer_remaining[i];
            end
        end
        return soon;
    endfunction

    // Update the timer state for one accepted word and queue the words it yields
    function automatic void apply_timer_word(input logic [KIND_W-1:0] kind,
                                             input logic [IDX_W-1:0]  idx,
                                             input logic [DATA_W-1:0] period,
                                             input logic [DATA_W-1:0] elapsed);
        timer_report_t rep;
        case (kind)
            KIND_START: begin
                if (timer_period[idx] == '0) begin
                    timer_period[idx]    = (period != '0) ? period : PERIOD_MIN;
                    timer_remaining[idx] = timer_period[idx];
                end
            end
            KIND_STOP: begin
                timer_period[idx] = '0;
            end
            KIND_ADVANCE: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (timer_period[i] != '0) begin
                        if (timer_remaining[i] > elapsed) begin
                            timer_remaining[i] = timer_remaining[i] - elapsed;
                        end else begin
                            // fire once and reload, no catch-up on missed periods
                            rep = '{is_expiry: 1'b1, fired_index: IDX_W'(i),
                                    next_timeout: '0, last: 1'b0};
                            pending_reports.push_back(rep);
                            timer_remaining[i] = timer_period[i];
                        end
                    end
                end
                rep = '{is_expiry: 1'b0, fired_index: '0,
                        next_timeout: soonest_remaining(), last: 1'b1};
                pending_reports.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [KIND_W-1:0] kind,
                             input logic [IDX_W-1:0]  idx,
                             input logic [DATA_W-1:0] period,
                             input logic [DATA_W-1:0] elapsed);
        int gap;
        gap = $urandom_range(0, send_gap_hi);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_timer_index <= idx;
        s_period      <= period;
        s_elapsed     <= elapsed;
        do @(posedge aclk); while (!s_ready);
        apply_timer_word(kind, idx, period, elapsed);
        words_sent++;
        if (kind == KIND_ADVANCE) advances_sent++;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 65) return DATA_W'($urandom_range(1, 40));
        if (r < 80) return DATA_W'($urandom_range(41, 1000));
        return DATA_W'($urandom);
    endfunction

    // Favor small steps and the exact boundary of the soonest timer
    function automatic logic [DATA_W-1:0] pick_elapsed();
        logic [DATA_W-1:0] soon;
        int r;
        soon = soonest_remaining();
        r = $urandom_range(0, 99);
        if (r < 40) return DATA_W'($urandom_range(0, 24));
        if (r < 60) return soon;
        if (r < 70) return soon - 1'b1;
        if (r < 85) return DATA_W'($urandom_range(0, 300));
        return DATA_W'($urandom);
    endfunction

    task automatic send_random_word();
        int r;
        logic [KIND_W-1:0] kind;
        r = $urandom_range(0, 99);
        if (r < 38)      kind = KIND_START;
        else if (r < 55) kind = KIND_STOP;
        else if (r < 95) kind = KIND_ADVANCE;
        else             kind = KIND_UNUSED;
        send_word(kind, IDX_W'($urandom_range(0, NUM_TIMERS - 1)), pick_period(),
                  pick_elapsed());
    endtask

    // Extremes, ignored words and the firing rules, one word at a time
    task automatic test_directed_cases();
        send_gap_hi = 0;
        recv_gap_hi = 0;
        send_word(KIND_ADVANCE, '0, '0, '0);
        send_word(KIND_ADVANCE, '0, '0, ALL_ONES);
        send_word(KIND_START, '0, '0, '0);
        send_word(KIND_START, '0, 32'd9, '0);
        send_word(KIND_START, LAST_IDX, ALL_ONES, '0);
        send_word(KIND_START, 4'd7, 32'd5, '0);
        send_word(KIND_STOP, 4'd3, ALL_ONES, ALL_ONES);
        send_word(KIND_UNUSED, '0, 32'd4, 32'd4);
        send_word(KIND_ADVANCE, '0, '0, '0);
        send_word(KIND_ADVANCE, '0, '0, 32'd1);
        send_word(KIND_ADVANCE, LAST_IDX, ALL_ONES, 32'd12);
        send_word(KIND_START, 4'd8, 32'h5555_5555, '0);
        send_word(KIND_START, 4'd9, 32'hAAAA_AAAA, '0);
        send_word(KIND_ADVANCE, '0, '0, ALL_ONES);
        send_word(KIND_STOP, LAST_IDX, '0, '0);
        send_word(KIND_STOP, '0, '0, '0);
        send_word(KIND_STOP, 4'd7, '0, '0);
        send_word(KIND_STOP, 4'd8, '0, '0);
        send_word(KIND_STOP, 4'd9, '0, '0);
        send_word(KIND_ADVANCE, '0, '0, 32'd3);
        drain_reports();
    endtask

    // Stall the output for a long stretch while advances keep coming
    task automatic test_output_backpressure();
        send_gap_hi = 0;
        recv_gap_hi = 3;
        for (int i = 0; i < 12; i++) begin
            send_word(KIND_START, IDX_W'(i), DATA_W'($urandom_range(1, 3)), '0);
        end
        receiver_hold = 400;
        for (int i = 0; i < 20; i++) begin
            send_word(KIND_ADVANCE, '0, '0, DATA_W'($urandom_range(1, 3)));
        end
        drain_reports();
        for (int i = 0; i < 12; i++) begin
            send_word(KIND_STOP, IDX_W'(i), '0, '0);
        end
        drain_reports();
    endtask

    // Random traffic at full rate on both sides
    task automatic test_random_steady();
        send_gap_hi = 0;
        recv_gap_hi = 0;
        repeat (80) send_random_word();
        drain_reports();
    endtask

    // Random traffic with random gaps and stalls on both sides
    task automatic test_random_with_gaps();
        send_gap_hi = 15;
        recv_gap_hi = 15;
        repeat (180) send_random_word();
        drain_reports();
    endtask

    // Short bursts, each sent only once the previous one has fully drained
    task automatic test_paused_bursts();
        send_gap_hi = 4;
        recv_gap_hi = 6;
        repeat (3) begin
            repeat (8) send_random_word();
            drain_reports();
        end
    endtask

    // Receiver: random stall before each word, plus any requested long hold-off
    initial begin : receiver
        int wait_cycles;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (receiver_hold > 0) begin
                wait_cycles   = receiver_hold;
                longest_hold  = receiver_hold;
                receiver_hold = 0;
            end else begin
                wait_cycles = $urandom_range(0, recv_gap_hi);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic note_mismatch(input string what, input timer_report_t want,
                                 input timer_report_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected expiry=%0b idx=%0d next=%h last=%0b,",
                     $realtime, what, want.is_expiry, want.fired_index,
                     want.next_timeout, want.last);
            $display("    got expiry=%0b idx=%0d next=%h last=%0b",
                     got.is_expiry, got.fired_index, got.next_timeout, got.last);
        end
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_reports
        timer_report_t got;
        timer_report_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{is_expiry: m_is_expiry, fired_index: m_fired_index,
                    next_timeout: m_next_timeout, last: m_last};
            if (got.is_expiry === 1'b1) fires_seen++;
            if (pending_reports.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (got !== want) note_mismatch("word mismatch", want, got);
            end
        end
    end

    // Run the tests in turn
    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_kind        <= KIND_START;
        s_timer_index <= '0;
        s_period      <= '0;
        s_elapsed     <= '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_period[i]    = '0;
            timer_remaining[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_steady();
        test_random_with_gaps();
        test_paused_bursts();

        $display("Sent %0d input words (%0d advances); checked %0d result words, %0d fired.",
                 words_sent, advances_sent, reports_checked, fires_seen);
        $display("Longest output hold-off %0d cycles; %0d mismatches.",
                 longest_hold, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
